### hdl/rpu_pkg.sv
// Shared types and constants for the RMSprop parameter update pipeline.
package rpu_pkg;

   localparam int FRAC_BITS  = 24;
   localparam int SQRT_STEPS = 28;   // root bits of a 56-bit radicand
   localparam int DIV_STEPS  = 58;   // quotient bits
   localparam int STEPS_PER_STG = 2;
   localparam int SQRT_STG   = SQRT_STEPS / STEPS_PER_STG;
   localparam int DIV_STG    = DIV_STEPS / STEPS_PER_STG;

   localparam logic [24:0] ONE_Q24  = 25'h100_0000;
   localparam logic [23:0] HALF_Q24 = 24'h80_0000;

   localparam logic [24:0] RST_LEARNING_RATE = 25'd167772;
   localparam logic [24:0] RST_DECAY_RATE    = 25'd16609444;
   localparam logic [24:0] RST_EPSILON       = 25'd1;
   localparam logic [24:0] RST_DECAY_WEIGHT  = 25'd0;

   typedef enum logic [2:0] {
      CSR_LEARNING_RATE = 3'd0,
      CSR_DECAY_RATE    = 3'd1,
      CSR_EPSILON       = 3'd2,
      CSR_DECAY_WEIGHT  = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] param_value;
      logic signed [31:0] grad_value;
      logic [31:0]        old_square_avg;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_param;
      logic [31:0]        new_square_avg;
      logic               saturated;
      logic               zero_denominator;
   } rsp_type;

   typedef struct packed {
      logic [24:0] learning_rate;
      logic [24:0] decay_rate;
      logic [24:0] epsilon;
      logic [24:0] decay_weight;
   } cfg_type;

   // Per-item data that rides along the root and divide pipelines.
   typedef struct packed {
      logic signed [31:0] p;
      logic               g_neg;
      logic [56:0]        num;
      logic [31:0]        nv;
      logic               sat;
   } side_type;

endpackage

### hdl/rpu_csr.sv
// Configuration register file for the RMSprop update.
module rpu_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [24:0]         csr_data,
   output rpu_pkg::cfg_type    cfg
);

   rpu_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            rpu_pkg::CSR_LEARNING_RATE: cfg_in.learning_rate = csr_data;
            rpu_pkg::CSR_DECAY_RATE:    cfg_in.decay_rate    = csr_data;
            rpu_pkg::CSR_EPSILON:       cfg_in.epsilon       = csr_data;
            rpu_pkg::CSR_DECAY_WEIGHT:  cfg_in.decay_weight  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.learning_rate <= rpu_pkg::RST_LEARNING_RATE;
         cfg_ff.decay_rate    <= rpu_pkg::RST_DECAY_RATE;
         cfg_ff.epsilon       <= rpu_pkg::RST_EPSILON;
         cfg_ff.decay_weight  <= rpu_pkg::RST_DECAY_WEIGHT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### hdl/rpu_front.sv
// Front stages: weight decay, gradient square, average update and lr*|g|.
module rpu_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  rpu_pkg::cfg_type    cfg,
   input  logic                in_valid,
   input  rpu_pkg::req_type    in_data,
   output logic                out_valid,
   output logic [55:0]         out_rad,
   output rpu_pkg::side_type   out_side
);

   logic [24:0] alpha, beta;

   // stage 1
   logic               v1_ff;
   logic signed [31:0] p1_ff, g1_ff;
   logic [31:0]        a1_ff;
   logic [56:0]        m1_ff, m1_in;
   logic [31:0]        pmag;
   // stage 2
   logic               v2_ff;
   logic signed [31:0] p2_ff;
   logic [31:0]        a2_ff, gm2_ff, gm2_in;
   logic               gneg2_ff, gneg2_in, sat2_ff, sat2_in;
   logic [32:0]        rdec;
   logic signed [34:0] gsum;
   logic signed [31:0] gcl;
   // stage 3
   logic               v3_ff, gneg3_ff, sat3_ff;
   logic signed [31:0] p3_ff;
   logic [63:0]        sq3_ff;
   logic [56:0]        av3_ff, num3_ff;
   // stage 4
   logic               v4_ff, gneg4_ff, sat4_ff;
   logic signed [31:0] p4_ff;
   logic [56:0]        av4_ff, num4_ff;
   logic [44:0]        pl4_ff;
   logic [43:0]        ph4_ff;
   logic [63:0]        sq_rnd;
   logic [38:0]        g2;
   // stage 5
   logic               v5_ff;
   logic [31:0]        nv5_in;
   logic               sat5_in;
   logic [64:0]        sum, sum_rnd;
   logic [40:0]        nv_full;
   rpu_pkg::side_type  side5_ff, side5_in;

   assign alpha = (cfg.decay_rate > rpu_pkg::ONE_Q24) ? rpu_pkg::ONE_Q24 : cfg.decay_rate;
   assign beta  = rpu_pkg::ONE_Q24 - alpha;

   always_comb begin
      pmag  = in_data.param_value[31] ? 32'(-in_data.param_value) : 32'(in_data.param_value);
      m1_in = 57'(cfg.decay_weight) * 57'(pmag);

      // decayed gradient, rounded and clamped
      rdec  = 33'((m1_ff + 57'(rpu_pkg::HALF_Q24)) >> rpu_pkg::FRAC_BITS);
      gsum  = p1_ff[31] ? 35'(g1_ff) - $signed({2'b00, rdec})
                        : 35'(g1_ff) + $signed({2'b00, rdec});
      sat2_in = 1'b0;
      if (gsum > 35'sd2147483647) begin
         gcl = 32'sh7fff_ffff;
         sat2_in = 1'b1;
      end else if (gsum < -35'sd2147483648) begin
         gcl = 32'sh8000_0000;
         sat2_in = 1'b1;
      end else begin
         gcl = gsum[31:0];
      end
      gneg2_in = gcl[31];
      gm2_in   = gcl[31] ? 32'(-gcl) : 32'(gcl);

      sq_rnd = sq3_ff + 64'(rpu_pkg::HALF_Q24);
      g2     = sq_rnd[62:24];

      sum     = 65'(av4_ff) + 65'(pl4_ff) + (65'(ph4_ff) << 20);
      sum_rnd = sum + 65'(rpu_pkg::HALF_Q24);
      nv_full = sum_rnd[64:24];
      if (nv_full > 41'h0_ffff_ffff) begin
         nv5_in  = 32'hffff_ffff;
         sat5_in = 1'b1;
      end else begin
         nv5_in  = nv_full[31:0];
         sat5_in = sat4_ff;
      end
      side5_in.p     = p4_ff;
      side5_in.g_neg = gneg4_ff;
      side5_in.num   = num4_ff;
      side5_in.nv    = nv5_in;
      side5_in.sat   = sat5_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff    <= in_data.param_value;
         g1_ff    <= in_data.grad_value;
         a1_ff    <= in_data.old_square_avg;
         m1_ff    <= m1_in;

         p2_ff    <= p1_ff;
         a2_ff    <= a1_ff;
         gm2_ff   <= gm2_in;
         gneg2_ff <= gneg2_in;
         sat2_ff  <= sat2_in;

         p3_ff    <= p2_ff;
         gneg3_ff <= gneg2_ff;
         sat3_ff  <= sat2_ff;
         sq3_ff   <= 64'(gm2_ff) * 64'(gm2_ff);
         av3_ff   <= 57'(alpha) * 57'(a2_ff);
         num3_ff  <= 57'(cfg.learning_rate) * 57'(gm2_ff);

         p4_ff    <= p3_ff;
         gneg4_ff <= gneg3_ff;
         sat4_ff  <= sat3_ff;
         av4_ff   <= av3_ff;
         num4_ff  <= num3_ff;
         pl4_ff   <= 45'(beta) * 45'(g2[19:0]);
         ph4_ff   <= 44'(beta) * 44'(g2[38:20]);

         side5_ff <= side5_in;
      end
   end

   assign out_valid = v5_ff;
   assign out_rad   = {side5_ff.nv, 24'd0};
   assign out_side  = side5_ff;

endmodule

### hdl/rpu_sqrt.sv
// Pipelined restoring integer square root, two root bits per stage.
module rpu_sqrt (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  logic [55:0]         in_rad,
   input  rpu_pkg::side_type   in_side,
   output logic                out_valid,
   output logic [27:0]         out_root,
   output rpu_pkg::side_type   out_side
);

   localparam int N = rpu_pkg::SQRT_STG;

   logic              v_ff    [N];
   logic [55:0]       rad_ff  [N], rad_in  [N];
   logic [29:0]       rem_ff  [N], rem_in  [N];
   logic [27:0]       root_ff [N], root_in [N];
   rpu_pkg::side_type side_ff [N];

   always_comb begin
      logic [55:0] x;
      logic [29:0] r;
      logic [27:0] q;
      logic [31:0] t, trial;
      for (int k = 0; k < N; k++) begin
         x = (k == 0) ? in_rad : rad_ff[(k == 0) ? 0 : k - 1];
         r = (k == 0) ? 30'd0  : rem_ff[(k == 0) ? 0 : k - 1];
         q = (k == 0) ? 28'd0  : root_ff[(k == 0) ? 0 : k - 1];
         for (int j = 0; j < rpu_pkg::STEPS_PER_STG; j++) begin
            t     = {r, x[55:54]};
            trial = {2'b00, q, 2'b01};
            x     = {x[53:0], 2'b00};
            if (t >= trial) begin
               t = t - trial;
               r = t[29:0];
               q = {q[26:0], 1'b1};
            end else begin
               r = t[29:0];
               q = {q[26:0], 1'b0};
            end
         end
         rad_in[k]  = x;
         rem_in[k]  = r;
         root_in[k] = q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < N; k++) v_ff[k] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
         for (int k = 1; k < N; k++) v_ff[k] <= v_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= in_side;
         for (int k = 1; k < N; k++) side_ff[k] <= side_ff[k-1];
         for (int k = 0; k < N; k++) begin
            rad_ff[k]  <= rad_in[k];
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
         end
      end
   end

   assign out_valid = v_ff[N-1];
   assign out_root  = root_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

### hdl/rpu_div.sv
// Pipelined rounded divide lr*|g| / (sqrt + eps), two quotient bits per stage.
module rpu_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic [24:0]         epsilon,
   input  logic                in_valid,
   input  logic [27:0]         in_root,
   input  rpu_pkg::side_type   in_side,
   output logic                out_valid,
   output logic [57:0]         out_quot,
   output logic                out_zden,
   output rpu_pkg::side_type   out_side
);

   localparam int N = rpu_pkg::DIV_STG;

   // setup stage: denominator and dividend with half the divisor added
   logic              v0_ff;
   logic [28:0]       d0_ff, d0_in;
   logic [57:0]       n0_ff;
   rpu_pkg::side_type side0_ff;

   logic              v_ff    [N];
   logic [28:0]       d_ff    [N];
   logic [57:0]       nq_ff   [N], nq_in  [N];
   logic [28:0]       rem_ff  [N], rem_in [N];
   rpu_pkg::side_type side_ff [N];

   assign d0_in = 29'(in_root) + 29'(epsilon);

   always_comb begin
      logic [57:0] x;
      logic [28:0] r, dd;
      logic [29:0] t;
      for (int k = 0; k < N; k++) begin
         x  = (k == 0) ? n0_ff : nq_ff[(k == 0) ? 0 : k - 1];
         r  = (k == 0) ? 29'd0 : rem_ff[(k == 0) ? 0 : k - 1];
         dd = (k == 0) ? d0_ff : d_ff[(k == 0) ? 0 : k - 1];
         for (int j = 0; j < rpu_pkg::STEPS_PER_STG; j++) begin
            t = {r, x[57]};
            x = {x[56:0], 1'b0};
            if (t >= {1'b0, dd}) begin
               t    = t - {1'b0, dd};
               x[0] = 1'b1;
            end
            r = t[28:0];
         end
         nq_in[k]  = x;
         rem_in[k] = r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         for (int k = 0; k < N; k++) v_ff[k] <= 1'b0;
      end else if (adv) begin
         v0_ff   <= in_valid;
         v_ff[0] <= v0_ff;
         for (int k = 1; k < N; k++) v_ff[k] <= v_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d0_ff      <= d0_in;
         n0_ff      <= 58'(in_side.num) + 58'(d0_in >> 1);
         side0_ff   <= in_side;
         d_ff[0]    <= d0_ff;
         side_ff[0] <= side0_ff;
         for (int k = 1; k < N; k++) begin
            d_ff[k]    <= d_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
         for (int k = 0; k < N; k++) begin
            nq_ff[k]  <= nq_in[k];
            rem_ff[k] <= rem_in[k];
         end
      end
   end

   assign out_valid = v_ff[N-1];
   assign out_quot  = nq_ff[N-1];
   assign out_zden  = (d_ff[N-1] == 29'd0);
   assign out_side  = side_ff[N-1];

endmodule

### hdl/rmsprop_param_update_top.sv
// Top level of the RMSprop element update pipeline with output register.

// Streams one parameter element per transaction and returns its RMSprop update.
// The pipeline takes a new transaction every cycle unless held by rsp_stall.
// Each passes 5 front stages for decay, squaring and the average, 14 square
// root stages, 1 denominator setup stage, 29 divide stages and the output
// register, which also takes the parameter step and clamp; the root and divide
// units resolve two bits per stage. The whole pipe holds while a result sits
// in the output register under rsp_stall, and req_stall is raised only then.
// The user must write registers through csr_* only while no transaction is in
// flight; the block does not enforce this. Out-of-range indexes are ignored.
module rmsprop_param_update_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rpu_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rpu_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [24:0]       csr_data
);

   rpu_pkg::cfg_type  cfg;
   logic              adv;

   logic              f_valid;
   logic [55:0]       f_rad;
   rpu_pkg::side_type f_side;

   logic              s_valid;
   logic [27:0]       s_root;
   rpu_pkg::side_type s_side;

   logic              d_valid, d_zden;
   logic [57:0]       d_quot;
   rpu_pkg::side_type d_side;

   logic              rsp_valid_ff;
   rpu_pkg::rsp_type  rsp_ff, rsp_in;
   logic signed [59:0] np_wide;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   rpu_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   rpu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (f_valid),
      .out_rad   (f_rad),
      .out_side  (f_side)
   );

   rpu_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (f_valid),
      .in_rad    (f_rad),
      .in_side   (f_side),
      .out_valid (s_valid),
      .out_root  (s_root),
      .out_side  (s_side)
   );

   rpu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .epsilon   (cfg.epsilon),
      .in_valid  (s_valid),
      .in_root   (s_root),
      .in_side   (s_side),
      .out_valid (d_valid),
      .out_quot  (d_quot),
      .out_zden  (d_zden),
      .out_side  (d_side)
   );

   always_comb begin
      np_wide = d_side.g_neg ? 60'(d_side.p) + $signed({2'b00, d_quot})
                             : 60'(d_side.p) - $signed({2'b00, d_quot});
      rsp_in.new_square_avg   = d_side.nv;
      rsp_in.zero_denominator = d_zden;
      rsp_in.saturated        = d_side.sat;
      if (d_zden) begin
         rsp_in.new_param = d_side.p;
      end else if (np_wide > 60'sd2147483647) begin
         rsp_in.new_param = 32'sh7fff_ffff;
         rsp_in.saturated = 1'b1;
      end else if (np_wide < -60'sd2147483648) begin
         rsp_in.new_param = 32'sh8000_0000;
         rsp_in.saturated = 1'b1;
      end else begin
         rsp_in.new_param = np_wide[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // pipeline holds only behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a stalled result");

   // zero denominator is only possible with epsilon cleared
   a_zden_eps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.zero_denominator) |-> (cfg.epsilon == 25'd0))
      else $error("zero denominator with nonzero epsilon");

   // a stalled result is still there next cycle
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled result dropped");

endmodule

### test/rmsprop_update_checker.sv
// Watches the request and response channels, predicts RMSprop updates and compares.
module rmsprop_update_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  rpu_pkg::req_type  req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  rpu_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [24:0]       csr_data,
   output int                fail_count,
   output int                pending_count,
   output int                rsp_count,
   output int                sat_count,
   output int                zden_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int EXP_DEPTH = 256;

   logic [24:0]      lr_q, alpha_q, eps_q, wd_q;
   rpu_pkg::rsp_type exp_mem [EXP_DEPTH];
   int               wr_ptr, rd_ptr;

   function automatic logic [63:0] isqrt(input logic [63:0] n);
      logic [63:0] root, bit_q, rem;
      root = 0;
      rem = n;
      bit_q = 64'd1 << 62;
      while (bit_q > rem) bit_q = bit_q >> 2;
      while (bit_q != 0) begin
         if (rem >= root + bit_q) begin
            rem = rem - (root + bit_q);
            root = (root >> 1) + bit_q;
         end else begin
            root = root >> 1;
         end
         bit_q = bit_q >> 2;
      end
      return root;
   endfunction

   function automatic longint clamp_s32(input longint v, inout logic sat);
      if (v > 64'sd2147483647) begin
         sat = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         sat = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic rpu_pkg::rsp_type predict_update(input rpu_pkg::req_type rq);
      rpu_pkg::rsp_type r;
      logic        sat;
      longint      p, g, np, delta;
      logic [63:0] alpha, gm, g2, sum, nv, s, d, m, num, pm;
      sat = 1'b0;
      p = longint'(rq.param_value);
      g = longint'(rq.grad_value);
      alpha = (alpha_q > rpu_pkg::ONE_Q24) ? 64'(rpu_pkg::ONE_Q24) : 64'(alpha_q);
      if (wd_q != 0) begin
         pm = (p < 0) ? 64'(-p) : 64'(p);
         m = 64'(wd_q) * pm;
         m = (m + 64'h80_0000) >> 24;
         g = clamp_s32(g + ((p < 0) ? -longint'(m) : longint'(m)), sat);
      end
      gm = (g < 0) ? 64'(-g) : 64'(g);
      g2 = (gm * gm + 64'h80_0000) >> 24;
      sum = alpha * 64'(rq.old_square_avg) + (64'(rpu_pkg::ONE_Q24) - alpha) * g2;
      nv = (sum + 64'h80_0000) >> 24;
      if (nv > 64'hFFFF_FFFF) begin
         nv = 64'hFFFF_FFFF;
         sat = 1'b1;
      end
      s = isqrt(nv << 24);
      d = s + 64'(eps_q);
      np = p;
      r.zero_denominator = (d == 0);
      if (d != 0) begin
         num = 64'(lr_q) * gm;
         delta = longint'((num + d / 2) / d);
         if (g < 0) delta = -delta;
         np = clamp_s32(p - delta, sat);
      end
      r.new_param = np[31:0];
      r.new_square_avg = nv[31:0];
      r.saturated = sat;
      return r;
   endfunction

   always @(posedge clock) begin
      rpu_pkg::rsp_type e;
      if (reset) begin
         lr_q <= rpu_pkg::RST_LEARNING_RATE;
         alpha_q <= rpu_pkg::RST_DECAY_RATE;
         eps_q <= rpu_pkg::RST_EPSILON;
         wd_q <= rpu_pkg::RST_DECAY_WEIGHT;
         wr_ptr <= 0;
         rd_ptr <= 0;
         fail_count <= 0;
         rsp_count <= 0;
         sat_count <= 0;
         zden_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               rpu_pkg::CSR_LEARNING_RATE: lr_q <= csr_data;
               rpu_pkg::CSR_DECAY_RATE:    alpha_q <= csr_data;
               rpu_pkg::CSR_EPSILON:       eps_q <= csr_data;
               rpu_pkg::CSR_DECAY_WEIGHT:  wd_q <= csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            exp_mem[wr_ptr % EXP_DEPTH] <= predict_update(req_data);
            wr_ptr <= wr_ptr + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_count <= rsp_count + 1;
            if (wr_ptr == rd_ptr) begin
               $display("%t: unexpected response, actual %h", $realtime, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               e = exp_mem[rd_ptr % EXP_DEPTH];
               rd_ptr <= rd_ptr + 1;
               sat_count <= sat_count + e.saturated;
               zden_count <= zden_count + e.zero_denominator;
               if (e.new_param !== rsp_data.new_param ||
                   e.new_square_avg !== rsp_data.new_square_avg ||
                   e.saturated !== rsp_data.saturated ||
                   e.zero_denominator !== rsp_data.zero_denominator) begin
                  $display("%t: mismatch, expected p=%h v=%h sat=%b zd=%b", $realtime,
                           e.new_param, e.new_square_avg, e.saturated,
                           e.zero_denominator);
                  $display("%t:           actual   p=%h v=%h sat=%b zd=%b", $realtime,
                           rsp_data.new_param, rsp_data.new_square_avg,
                           rsp_data.saturated, rsp_data.zero_denominator);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

   assign pending_count = wr_ptr - rd_ptr;
endmodule

### test/tb_top.sv
// Stimulus and verdict for the RMSprop parameter update pipeline.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 50;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   rpu_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b1;
   rpu_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [2:0]       csr_index = '0;
   logic [24:0]      csr_data = '0;
   int               fail_count, pending_count, rsp_count, sat_count, zden_count;
   int               holdoff_cycles = 0;
   int               sent_count = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   rmsprop_param_update_top u_top (.*);

   rmsprop_update_checker u_chk (.*);

   // Response side: random stalls, plus a long hold-off on request.
   initial begin
      @(posedge clock iff !reset);
      forever begin
         if (holdoff_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (holdoff_cycles) @(posedge clock);
            holdoff_cycles = 0;
         end else if ($urandom_range(3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(14)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   task automatic send_item(input rpu_pkg::req_type rq, input bit gaps);
      int gap;
      gap = gaps ? (($urandom_range(2) == 0) ? $urandom_range(14) : 0) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   task automatic drain_pipe();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_csr(input rpu_pkg::csr_index_type idx, input logic [24:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(5))
         0: return 32'h8000_0000 + $urandom_range(3);
         1: return 32'h7FFF_FFFF - $urandom_range(3);
         2: return $urandom_range(32'h0200_0000) - 32'h0100_0000;
         3: return $urandom_range(255) - 128;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [24:0] rand_reg();
      case ($urandom_range(4))
         0: return 25'd0;
         1: return rpu_pkg::ONE_Q24;
         2: return 25'h1FF_FFFF;
         default: return 25'($urandom);
      endcase
   endfunction

   initial begin
      rpu_pkg::req_type rq;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items at reset settings
      for (int k = 0; k < 24; k++) begin
         rq.param_value    = (k % 3 == 0) ? 32'h7FFF_FFFF : (k % 3 == 1) ? 32'h8000_0000 : 0;
         rq.grad_value     = (k % 4 == 0) ? 32'h7FFF_FFFF : (k % 4 == 1) ? 32'h8000_0000 :
                             (k % 4 == 2) ? 32'hFFFF_FFFF : 0;
         rq.old_square_avg = (k < 8) ? 32'hFFFF_FFFF : (k < 16) ? 0 : 32'h0100_0000;
         send_item(rq, 1'b0);
      end
      drain_pipe();
      // Zero denominator, alpha above one, saturating decay and step
      write_csr(rpu_pkg::CSR_EPSILON, 25'd0);
      write_csr(rpu_pkg::CSR_DECAY_RATE, 25'h1FF_FFFF);
      write_csr(rpu_pkg::CSR_DECAY_WEIGHT, rpu_pkg::ONE_Q24);
      write_csr(rpu_pkg::CSR_LEARNING_RATE, rpu_pkg::ONE_Q24);
      write_csr(rpu_pkg::csr_index_type'(3'd6), 25'd5);   // ignored index
      for (int k = 0; k < 8; k++) begin
         rq.param_value    = k[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
         rq.grad_value     = k[1] ? 32'h7000_0000 : 32'h9000_0000;
         rq.old_square_avg = k[2] ? 32'hFFFF_FFFF : 0;
         send_item(rq, 1'b0);
      end
      drain_pipe();

      // Random phases with fresh settings
      for (int ph = 0; ph < 12; ph++) begin
         write_csr(rpu_pkg::CSR_LEARNING_RATE, (ph == 0) ? 25'd0 : rand_reg());
         write_csr(rpu_pkg::CSR_DECAY_RATE, (ph == 1) ? 25'd0 : rand_reg());
         write_csr(rpu_pkg::CSR_EPSILON,
                   (ph == 2) ? 25'h1FF_FFFF : (ph % 3 == 0) ? 25'd0 : rand_reg());
         write_csr(rpu_pkg::CSR_DECAY_WEIGHT, (ph == 3) ? 25'h1FF_FFFF : rand_reg());
         if (ph == 4) holdoff_cycles = 300;
         for (int k = 0; k < 155; k++) begin
            rq.param_value    = rand_word();
            rq.grad_value     = rand_word();
            rq.old_square_avg = ($urandom_range(4) == 0) ? $urandom_range(4) : rand_word();
            send_item(rq, (ph % 4) != 1);
         end
         drain_pipe();
      end

      $display("Run covered %0d transactions over 14 register settings;", sent_count);
      $display("%0d responses, %0d saturated, %0d zero denominator.",
               rsp_count, sat_count, zden_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("** rmsprop_param_update_top: PASSED **");
      end else begin
         $display("** rmsprop_param_update_top: FAILED **");
      end
      $finish;
   end

   initial begin
      #8ms;
      $display("** rmsprop_param_update_top: FAILED **");
      $finish;
   end
endmodule
